/* design/tpz_pkg.sv */
// package for the torus point plotter: sizes, payload types and sine table
package tpz_pkg;

  localparam int MAJOR_RADIUS = 20;
  localparam int MINOR_RADIUS = 10;
  localparam int MARGIN       = 4;
  localparam int SHADE_LEVELS = 12;
  localparam int ANGLE_BITS   = 10;

  localparam int GRID_ROWS  = MAJOR_RADIUS + MINOR_RADIUS + MARGIN;
  localparam int GRID_COLS  = 2 * GRID_ROWS;
  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

  localparam logic [4:0]        GLYPH_BLANK = 5'd31;
  localparam logic signed [7:0] DEPTH_EMPTY = -8'sd100;
  localparam int                COS45_Q14   = 11585;

  typedef struct packed {
    logic       func;
    logic [9:0] tube_angle;
    logic [9:0] ring_angle;
    logic [9:0] tilt_angle;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic              drawn;
    logic [5:0]        cell_row;
    logic [6:0]        cell_col;
    logic              cell_blank;
    logic [3:0]        shade;
    logic signed [7:0] cell_depth;
  } out_item_t;

  typedef logic signed [15:0] sin_tab_t [QUARTER+1];

  // quarter-wave sine in q2.14, polynomial worked out at elaboration
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint   x, x2, u, v, s;
    for (int i = 0; i <= QUARTER; i++) begin
      x  = longint'(i) << (18 - ANGLE_BITS);
      x2 = (x * x) >>> 16;
      u  = 42047 - ((4640 * x2) >>> 16);
      u  = 102944 - ((u * x2) >>> 16);
      v  = (u * x) >>> 16;
      s  = (v + 2) >>> 2;
      if (s > 16384) s = 16384;
      t[i] = 16'(s);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic signed [15:0] sin_lookup(logic [ANGLE_BITS-1:0] ph);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] q;
    logic [ANGLE_BITS-2:0] idx;
    logic signed [15:0]    s;
    quad = ph[ANGLE_BITS-1:ANGLE_BITS-2];
    q    = ph[ANGLE_BITS-3:0];
    idx  = quad[0] ? (ANGLE_BITS-1)'(QUARTER - int'(q)) : {1'b0, q};
    s    = SIN_TAB[idx];
    return quad[1] ? -s : s;
  endfunction

endpackage

/* design/torus_point_zbuffer_plotter.sv */
// torus point plotter with depth-buffered character grid
//
//  channel | ports                         | moves
//  --------+-------------------------------+---------------------------------
//  input   | in_valid  in_stall  in_data   | plot sample or read-and-clear
//  output  | out_valid out_stall out_data  | one result per input transfer
//
// after reset a clearing pass writes blank / -100 to all 2312 cells, one per
// cycle, with in_stall held high until the pass is done
// a plot goes through accept with sine lookups, 15 steps of the shared
// multiplier, cell mapping, then the grid memory read and write-back
// a read goes through accept, memory read, check and clear
// one item at a time; the result register lets the next item start while a
// result is still waiting, the write-back stage holds while it waits and out_stall is high
module torus_point_zbuffer_plotter
  import tpz_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ACC_W  = 60;
  localparam int MA_W   = 30;
  localparam int MB_W   = 22;
  localparam int PR_W   = MA_W + MB_W;
  localparam int TR_W   = 44;
  localparam int LAST_STEP = 14;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_FIN    = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_MEM    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // grid memory: {glyph, depth}
  logic [12:0] grid_mem [GRID_CELLS];
  logic [12:0] rdata_r;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [12:0] mem_wd;

  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] cell_addr_r, cell_addr_nxt;

  // sine/cosine of the three angles, ring radius term
  logic signed [15:0] st_r, ct_r, sp_r, cp_r, sa_r, ca_r;
  logic signed [15:0] st_nxt, ct_nxt, sp_nxt, cp_nxt, sa_nxt, ca_nxt;
  logic signed [MB_W-1:0] w_r, w_nxt;

  logic [3:0] step_r, step_nxt;
  logic signed [MA_W-1:0] tmp_r, tmp_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  // triple product of the normal, applied to the light in two halves
  logic signed [TR_W-1:0] trip_r, trip_nxt;
  logic signed [ACC_W-1:0] x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic signed [ACC_W-1:0] z_acc_r, z_acc_nxt, n_acc_r, n_acc_nxt;
  logic signed [23:0] val_r, val_nxt;

  logic        func_r, func_nxt;
  logic        in_grid_r, in_grid_nxt;
  logic [5:0]  row_r, row_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [3:0]  shade_r, shade_nxt;
  logic signed [7:0]  zi_r, zi_nxt;
  logic signed [23:0] z8_r, z8_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod;
  assign prod = mul_a * mul_b;

  localparam logic signed [MB_W-1:0] RQ = MB_W'(MINOR_RADIUS * 16384);
  localparam logic signed [MB_W-1:0] KL = MB_W'(COS45_Q14);
  localparam logic signed [MB_W-1:0] LV = MB_W'(SHADE_LEVELS - 1);

  // light dot product, rounded out of q42
  logic signed [ACC_W-1:0] n_rnd;
  logic signed [18:0]      dot;
  assign n_rnd = n_acc_r + (ACC_W'(1) <<< 41);
  assign dot   = 19'(n_rnd >>> 42);

  // cell mapping terms
  logic signed [ACC_W-1:0] x_rnd, y_rnd, z_rnd;
  logic signed [23:0] x8, y8, z8, rnum, zmag;
  logic signed [15:0] col_f, row_f;
  logic [23:0] mag;
  logic [8:0]  kq;
  logic signed [15:0] zt;
  logic        grid_hit;
  logic signed [7:0] held;
  logic        out_free;

  assign x_rnd = x_acc_r + (ACC_W'(1) <<< 19);
  assign y_rnd = y_acc_r + (ACC_W'(1) <<< 33);
  assign z_rnd = z_acc_r + (ACC_W'(1) <<< 33);
  assign x8    = 24'(x_rnd >>> 20);
  assign y8    = 24'(y_rnd >>> 34);
  assign z8    = 24'(z_rnd >>> 34);
  assign rnum  = y8 + 24'(GRID_ROWS * 256);
  assign col_f = 16'(x8 >>> 8) + 16'(GRID_ROWS);
  assign row_f = 16'(rnum >>> 9);
  assign mag   = val_r[23] ? 24'(-val_r) : 24'(val_r);
  assign kq    = 9'(mag >> 15);
  assign zmag  = z8[23] ? -z8 : z8;
  assign zt    = z8[23] ? -16'(zmag >>> 8) : 16'(z8 >>> 8);
  assign grid_hit = (row_f >= 0) && (row_f < 16'(GRID_ROWS)) &&
                    (col_f >= 0) && (col_f < 16'(GRID_COLS));
  assign held     = rdata_r[7:0];
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mul_a = MA_W'(cp_r);
    mul_b = w_r;
    case (step_r)
      4'd0:  begin mul_a = MA_W'(cp_r); mul_b = w_r; end
      4'd1:  begin mul_a = MA_W'(ca_r); mul_b = MB_W'(st_r); end
      4'd2:  begin mul_a = MA_W'(sa_r); mul_b = MB_W'(sp_r); end
      4'd3:  begin mul_a = p3_r; mul_b = w_r; end
      4'd4:  begin mul_a = p2_r; mul_b = RQ; end
      4'd5:  begin mul_a = MA_W'(sa_r); mul_b = MB_W'(st_r); end
      4'd6:  begin mul_a = tmp_r; mul_b = RQ; end
      4'd7:  begin mul_a = MA_W'(ca_r); mul_b = MB_W'(sp_r); end
      4'd8:  begin mul_a = tmp_r; mul_b = w_r; end
      4'd9:  begin mul_a = MA_W'(cp_r); mul_b = MB_W'(ct_r); end
      4'd10: begin mul_a = tmp_r + p2_r; mul_b = KL; end
      4'd11: begin mul_a = p3_r; mul_b = MB_W'(ct_r); end
      4'd12: begin mul_a = MA_W'(trip_r >>> 21); mul_b = KL; end
      4'd13: begin mul_a = MA_W'({1'b0, trip_r[20:0]}); mul_b = KL; end
      4'd14: begin mul_a = MA_W'(19'sd16384 - dot); mul_b = LV; end
      default: begin mul_a = MA_W'(cp_r); mul_b = w_r; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cell_addr_nxt = cell_addr_r;
    st_nxt = st_r; ct_nxt = ct_r; sp_nxt = sp_r;
    cp_nxt = cp_r; sa_nxt = sa_r; ca_nxt = ca_r;
    w_nxt     = w_r;
    step_nxt  = step_r;
    tmp_nxt   = tmp_r;
    p2_nxt    = p2_r;
    p3_nxt    = p3_r;
    trip_nxt  = trip_r;
    x_acc_nxt = x_acc_r;
    y_acc_nxt = y_acc_r;
    z_acc_nxt = z_acc_r;
    n_acc_nxt = n_acc_r;
    val_nxt   = val_r;
    func_nxt  = func_r;
    in_grid_nxt = in_grid_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    shade_nxt = shade_r;
    zi_nxt    = zi_r;
    z8_nxt    = z8_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we = 1'b0;
    mem_wa = cell_addr_r;
    mem_wd = {GLYPH_BLANK, DEPTH_EMPTY};

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(GRID_CELLS - 1)) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_data.func;
          // table lookups for the three angles
          st_nxt = sin_lookup(in_data.tube_angle[ANGLE_BITS-1:0]);
          ct_nxt = sin_lookup(ANGLE_BITS'(in_data.tube_angle[ANGLE_BITS-1:0] + QUARTER));
          sp_nxt = sin_lookup(in_data.ring_angle[ANGLE_BITS-1:0]);
          cp_nxt = sin_lookup(ANGLE_BITS'(in_data.ring_angle[ANGLE_BITS-1:0] + QUARTER));
          sa_nxt = sin_lookup(in_data.tilt_angle[ANGLE_BITS-1:0]);
          ca_nxt = sin_lookup(ANGLE_BITS'(in_data.tilt_angle[ANGLE_BITS-1:0] + QUARTER));
          w_nxt  = MB_W'(MAJOR_RADIUS * 16384) + MB_W'(MINOR_RADIUS) * MB_W'(ct_nxt);
          step_nxt = 4'd0;
          row_nxt  = in_data.read_row;
          col_nxt  = in_data.read_col;
          in_grid_nxt = (in_data.read_row < 6'(GRID_ROWS)) &&
                        (in_data.read_col < 7'(GRID_COLS));
          cell_addr_nxt = in_grid_nxt ?
            ADDR_W'(int'(in_data.read_row) * GRID_COLS + int'(in_data.read_col)) : '0;
          state_nxt = in_data.func ? ST_RDWAIT : ST_MUL;
        end
      end

      ST_MUL: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          4'd0:  x_acc_nxt = ACC_W'(prod);
          4'd1:  p2_nxt = MA_W'(prod);
          4'd2:  p3_nxt = MA_W'(prod);
          4'd3:  y_acc_nxt = ACC_W'(prod);
          4'd4:  y_acc_nxt = y_acc_r + ACC_W'(prod);
          4'd5:  tmp_nxt = MA_W'(prod);
          4'd6:  z_acc_nxt = ACC_W'(prod);
          4'd7:  tmp_nxt = MA_W'(prod);
          4'd8:  z_acc_nxt = z_acc_r - ACC_W'(prod);
          4'd9:  tmp_nxt = MA_W'(prod);
          4'd10: n_acc_nxt = -(ACC_W'(prod) <<< 14);
          4'd11: trip_nxt = TR_W'(prod);
          // upper part of the triple product, then the low 21 bits
          4'd12: n_acc_nxt = n_acc_r - (ACC_W'(prod) <<< 21);
          4'd13: n_acc_nxt = n_acc_r - ACC_W'(prod);
          4'd14: val_nxt = 24'(prod);
          default: ;
        endcase
        if (step_r == 4'(LAST_STEP)) state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // shade index from light dot, grid cell from projected point
        shade_nxt = (kq > 9'(SHADE_LEVELS - 1)) ? 4'd0 :
                    4'(SHADE_LEVELS - 1) - kq[3:0];
        in_grid_nxt = grid_hit;
        if (row_f < 0) row_nxt = 6'd0;
        else if (row_f >= 16'(GRID_ROWS)) row_nxt = 6'(GRID_ROWS - 1);
        else row_nxt = row_f[5:0];
        if (col_f < 0) col_nxt = 7'd0;
        else if (col_f >= 16'(GRID_COLS)) col_nxt = 7'(GRID_COLS - 1);
        else col_nxt = col_f[6:0];
        cell_addr_nxt = ADDR_W'(int'(row_nxt) * GRID_COLS + int'(col_nxt));
        z8_nxt = z8;
        if (zt > 16'sd127) zi_nxt = 8'sd127;
        else if (zt < -16'sd128) zi_nxt = -8'sd128;
        else zi_nxt = zt[7:0];
        state_nxt = ST_RDWAIT;
      end

      ST_RDWAIT: state_nxt = ST_MEM;

      ST_MEM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.cell_row = row_r;
          out_data_nxt.cell_col = col_r;
          state_nxt = ST_IDLE;
          if (func_r) begin
            out_data_nxt.drawn = 1'b0;
            if (in_grid_r) begin
              out_data_nxt.cell_blank = (rdata_r[12:8] == GLYPH_BLANK);
              out_data_nxt.shade = (rdata_r[12:8] == GLYPH_BLANK) ? 4'd0 : rdata_r[11:8];
              out_data_nxt.cell_depth = held;
              mem_we = 1'b1;
            end else begin
              out_data_nxt.cell_blank = 1'b1;
              out_data_nxt.shade = 4'd0;
              out_data_nxt.cell_depth = DEPTH_EMPTY;
            end
          end else begin
            out_data_nxt.cell_blank = 1'b0;
            out_data_nxt.shade = shade_r;
            if (!in_grid_r) begin
              out_data_nxt.drawn = 1'b0;
              out_data_nxt.cell_depth = DEPTH_EMPTY;
            end else if ((24'(held) <<< 8) < z8_r) begin
              // nearer than held depth: take the cell
              out_data_nxt.drawn = 1'b1;
              out_data_nxt.cell_depth = zi_r;
              mem_we = 1'b1;
              mem_wd = {1'b0, shade_r, zi_r};
            end else begin
              out_data_nxt.drawn = 1'b0;
              out_data_nxt.cell_depth = held;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    rdata_r <= grid_mem[cell_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_addr_r <= cell_addr_nxt;
    st_r <= st_nxt; ct_r <= ct_nxt; sp_r <= sp_nxt;
    cp_r <= cp_nxt; sa_r <= sa_nxt; ca_r <= ca_nxt;
    w_r     <= w_nxt;
    tmp_r   <= tmp_nxt;
    p2_r    <= p2_nxt;
    p3_r    <= p3_nxt;
    trip_r  <= trip_nxt;
    x_acc_r <= x_acc_nxt;
    y_acc_r <= y_acc_nxt;
    z_acc_r <= z_acc_nxt;
    n_acc_r <= n_acc_nxt;
    val_r   <= val_nxt;
    func_r  <= func_nxt;
    in_grid_r <= in_grid_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    shade_r <= shade_nxt;
    zi_r    <= zi_nxt;
    z8_r    <= z8_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* sim/tb_torus_point_zbuffer_plotter.sv */
// self-checking testbench for the torus point plotter with depth-buffered grid
module tb_torus_point_zbuffer_plotter;
  import tpz_pkg::*;

  // cycles with no transfer on either side before the run is abandoned;
  // covers the clearing pass after reset plus the longest receiver hold-off
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  torus_point_zbuffer_plotter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // shadow copy of the grid: glyph code and integer depth per cell
  logic [4:0]        grid_glyph [GRID_CELLS];
  logic signed [7:0] grid_depth [GRID_CELLS];

  out_item_t pending_cells [$];   // results still owed by the block
  int        lit_rows [$];        // cells that took a surface point, for reads
  int        lit_cols [$];
  int        fail_count;
  int        idle_cycles;
  int        gap_pct;             // chance of a gap after each input transfer
  int        stall_pct;           // chance of holding the result channel
  bit        hold_long;           // request for a long receiver hold-off

  // clock: period 8
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sine of a phase in q2.14 from the quarter-wave polynomial
  function automatic longint phase_sine(int ph);
    int     p, quad;
    longint x, x2, u, v, s;
    p    = ph & ((1 << ANGLE_BITS) - 1);
    quad = p >> (ANGLE_BITS - 2);
    x    = longint'(p & (QUARTER - 1)) << (18 - ANGLE_BITS);
    if (quad & 1) x = 65536 - x;
    x2 = (x * x) >>> 16;
    u  = 42047 - ((4640 * x2) >>> 16);
    u  = 102944 - ((u * x2) >>> 16);
    v  = (u * x) >>> 16;
    s  = (v + 2) >>> 2;
    if (s > 16384) s = 16384;
    return (quad & 2) ? -s : s;
  endfunction

  function automatic longint round_down_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // works out the result of one accepted item and updates the shadow grid
  task automatic predict_cell(input in_item_t it);
    out_item_t r;
    longint    st, ct, sp, cp, sa, ca, w, x8, y8, z8, nx, ny, d, val, mag, k;
    longint    row, col, zi, held;
    int        idx;
    r = '0;
    if (it.func) begin
      row = it.read_row;
      col = it.read_col;
      r.cell_row = it.read_row;
      r.cell_col = it.read_col;
      if (row < GRID_ROWS && col < GRID_COLS) begin
        idx          = int'(row * GRID_COLS + col);
        r.cell_blank = (grid_glyph[idx] == GLYPH_BLANK);
        r.shade      = r.cell_blank ? 4'd0 : grid_glyph[idx][3:0];
        r.cell_depth = grid_depth[idx];
        // read clears the cell
        grid_glyph[idx] = GLYPH_BLANK;
        grid_depth[idx] = DEPTH_EMPTY;
      end else begin
        r.cell_blank = 1'b1;
        r.cell_depth = DEPTH_EMPTY;
      end
    end else begin
      st = phase_sine(it.tube_angle);
      ct = phase_sine(it.tube_angle + QUARTER);
      sp = phase_sine(it.ring_angle);
      cp = phase_sine(it.ring_angle + QUARTER);
      sa = phase_sine(it.tilt_angle);
      ca = phase_sine(it.tilt_angle + QUARTER);
      w  = longint'(MAJOR_RADIUS) * 16384 + longint'(MINOR_RADIUS) * ct;
      x8 = round_down_shift(cp * w, 20);
      y8 = round_down_shift(longint'(MINOR_RADIUS) * ca * st * 16384 + sa * sp * w, 34);
      z8 = round_down_shift(longint'(MINOR_RADIUS) * sa * st * 16384 - ca * sp * w, 34);
      nx = cp * ct * 16384;
      ny = ca * st * 16384 + sa * sp * ct;
      d  = round_down_shift(-(nx + ny) * COS45_Q14, 42);
      val = longint'(SHADE_LEVELS - 1) * (16384 - d);
      mag = (val < 0) ? -val : val;
      k   = mag / 32768;
      if (k > SHADE_LEVELS - 1) k = SHADE_LEVELS - 1;
      r.shade = 4'(SHADE_LEVELS - 1 - k);
      row = (y8 + longint'(GRID_ROWS) * 256) >>> 9;
      col = (x8 + longint'(GRID_ROWS) * 256) >>> 8;
      if (row < 0 || row >= GRID_ROWS || col < 0 || col >= GRID_COLS) begin
        // off the grid: clamped position, nothing written
        if (row < 0) row = 0;
        if (row >= GRID_ROWS) row = GRID_ROWS - 1;
        if (col < 0) col = 0;
        if (col >= GRID_COLS) col = GRID_COLS - 1;
        r.cell_row   = 6'(row);
        r.cell_col   = 7'(col);
        r.cell_depth = DEPTH_EMPTY;
      end else begin
        idx        = int'(row * GRID_COLS + col);
        held       = grid_depth[idx];
        r.cell_row = 6'(row);
        r.cell_col = 7'(col);
        if (held * 256 < z8) begin
          // depth truncated toward zero, then saturated
          zi = (z8 < 0) ? -((-z8) >>> 8) : (z8 >>> 8);
          if (zi > 127) zi = 127;
          if (zi < -128) zi = -128;
          grid_depth[idx] = 8'(zi);
          grid_glyph[idx] = 5'(r.shade);
          r.drawn         = 1'b1;
          r.cell_depth    = 8'(zi);
          lit_rows.push_back(int'(row));
          lit_cols.push_back(int'(col));
        end else begin
          r.cell_depth = 8'(held);
        end
      end
    end
    pending_cells.push_back(r);
  endtask

  // offers one item, waits for its transfer, then maybe leaves a gap
  task automatic send_item(input in_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_cell(it);
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t plot_item(int t, int p, int a);
    in_item_t it;
    it            = '0;
    it.func       = 1'b0;
    it.tube_angle = 10'(t);
    it.ring_angle = 10'(p);
    it.tilt_angle = 10'(a);
    // unused fields carry noise
    it.read_row   = 6'($urandom);
    it.read_col   = 7'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(int row, int col);
    in_item_t it;
    it            = '0;
    it.func       = 1'b1;
    it.read_row   = 6'(row);
    it.read_col   = 7'(col);
    it.tube_angle = 10'($urandom);
    it.ring_angle = 10'($urandom);
    it.tilt_angle = 10'($urandom);
    return it;
  endfunction

  // read of a cell that has been lit, or any in-grid cell if none are known
  task automatic read_lit_cell();
    int i;
    if (lit_rows.size() > 0) begin
      i = $urandom_range(0, lit_rows.size() - 1);
      send_item(read_item(lit_rows[i], lit_cols[i]));
    end else begin
      send_item(read_item($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reads of untouched cells, the grid corners and addresses off the grid
  task automatic test_blank_reads();
    send_item(read_item(0, 0));
    send_item(read_item(GRID_ROWS - 1, GRID_COLS - 1));
    send_item(read_item(GRID_ROWS, 0));
    send_item(read_item(0, GRID_COLS));
    send_item(read_item(63, 127));
  endtask

  // angle extremes and quarter-turn points on every phase input
  task automatic test_angle_extremes();
    send_item(plot_item(0, 0, 0));
    send_item(plot_item(1023, 1023, 1023));
    send_item(plot_item(256, 0, 0));
    send_item(plot_item(0, 256, 512));
    send_item(plot_item(512, 768, 256));
    send_item(plot_item(768, 512, 768));
    send_item(plot_item(0, 0, 0));        // same point again: fails depth test
    send_item(plot_item(341, 682, 1023));
  endtask

  // lit cells read back and cleared, then read again as blank
  task automatic test_plot_then_read();
    send_item(plot_item(100, 200, 300));
    read_lit_cell();
    send_item(plot_item(100, 200, 300));
    read_lit_cell();
    read_lit_cell();
    send_item(plot_item(900, 50, 700));
    read_lit_cell();
  endtask

  // mostly plots with random phases, reads aimed at lit cells and noise reads
  task automatic test_random_mix(input int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      // stretches with no idling on either side, alternating with stretches of random gaps and stalls
      if (n % 200 == 0) begin
        gap_pct   = (n % 400 == 0) ? 0 : 30;
        stall_pct = (n % 400 == 0) ? 0 : 25;
      end
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_item(plot_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023)));
      end else if (sel < 85) begin
        read_lit_cell();
      end else if (sel < 95) begin
        send_item(read_item($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1)));
      end else begin
        send_item(read_item($urandom_range(0, 63), $urandom_range(0, 127)));
      end
    end
  endtask

  // receiver holds off for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    gap_pct   = 0;
    hold_long = 1'b1;
    for (int n = 0; n < 20; n++) begin
      if (n % 3 == 2) read_lit_cell();
      else send_item(plot_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023)));
    end
    gap_pct = 30;
  endtask

  // ------------------------------------------------------------ processes

  // result channel stall: random short and long holds, plus the requested
  // long hold-off counted here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if ($urandom_range(0, 199) == 0 && stall_pct > 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // checks every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        $error("result transfer with no prediction waiting");
        fail_count++;
      end else begin
        compare_field("drawn", pending_cells[0].drawn, out_data.drawn);
        compare_field("cell_row", pending_cells[0].cell_row, out_data.cell_row);
        compare_field("cell_col", pending_cells[0].cell_col, out_data.cell_col);
        compare_field("cell_blank", pending_cells[0].cell_blank, out_data.cell_blank);
        compare_field("shade", pending_cells[0].shade, out_data.shade);
        compare_field("cell_depth", pending_cells[0].cell_depth, out_data.cell_depth);
        void'(pending_cells.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    fail_count  = 0;
    idle_cycles = 0;
    gap_pct     = 30;
    stall_pct   = 25;
    hold_long   = 1'b0;
    for (int i = 0; i < GRID_CELLS; i++) begin
      grid_glyph[i] = GLYPH_BLANK;
      grid_depth[i] = DEPTH_EMPTY;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_blank_reads();
    test_angle_extremes();
    test_plot_then_read();
    test_backpressure();
    test_random_mix(1000);
    in_valid <= 1'b0;

    // drain, then allow for the write-back latency
    while (pending_cells.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
